### hw/rtl/sogh_pkg.sv
package sogh_pkg;

    // Store and datapath sizes.
    localparam int MAX_CLASSES = 8;
    localparam int ACC_WIDTH   = 48;
    localparam int NUM_SCORES  = 8;
    localparam int MODE_W      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int SCORE_W     = 16;
    localparam int ARG_W       = 18;
    localparam int EXP_W       = 17;
    localparam int Y_W         = ARG_W + 17 - 12;
    localparam int VAL_W       = 23;
    localparam int SUM_W       = 26;
    localparam int ESUM_W      = 20;
    localparam int DELTA_W     = 32;
    localparam int H0_W        = 28;
    localparam int OUT_W       = 48;
    localparam int CNT_W       = 32;

    // Fixed point constants.
    localparam int Q16_ONE   = 65536;
    localparam int LOG2E_Q16 = 94548;
    localparam int LN2_Q12   = 2839;

    // Command codes.
    localparam logic [2:0] CMD_ADD_ALL   = 3'd0;
    localparam logic [2:0] CMD_SUB_ALL   = 3'd1;
    localparam logic [2:0] CMD_ADD_ONE   = 3'd2;
    localparam logic [2:0] CMD_SUB_ONE   = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
    localparam logic [2:0] CMD_CLEAR_ONE = 3'd5;

    // Register indexes.
    localparam logic [1:0] REG_NUM_CLASSES = 2'd0;
    localparam logic [1:0] REG_MODE_MASK   = 2'd1;
    localparam logic [1:0] REG_STRENGTH    = 2'd2;

    typedef struct packed {
        logic [2:0]                cmd;
        logic [2:0]                label;
        logic [2:0]                mode_id;
        logic signed [SCORE_W-1:0] score_0;
        logic signed [SCORE_W-1:0] score_1;
        logic signed [SCORE_W-1:0] score_2;
        logic signed [SCORE_W-1:0] score_3;
        logic signed [SCORE_W-1:0] score_4;
        logic signed [SCORE_W-1:0] score_5;
        logic signed [SCORE_W-1:0] score_6;
        logic signed [SCORE_W-1:0] score_7;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] gradient_sum;
        logic signed [OUT_W-1:0] hessian_sum;
        logic signed [CNT_W-1:0] sample_count;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [EXP_W-1:0]  em;
        logic [ESUM_W-1:0] esum;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [EXP_W-1:0] q;
    } div_rsp_t;

    // Mantissa table of 2^(-j/16) in Q16.
    function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] idx);
        logic [EXP_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/sogh_lane.sv
module sogh_lane (
    input  logic                           clk,
    input  logic signed [sogh_pkg::ARG_W-1:0] arg,
    output logic [sogh_pkg::EXP_W-1:0]     value
);
    import sogh_pkg::*;

    logic [ARG_W-1:0]        mag;
    logic [ARG_W+17-1:0]     yprod;
    logic [Y_W-1:0]          y_reg;
    logic [6:0]              k;
    logic [3:0]              idx;
    logic [11:0]             fr;
    logic [EXP_W-1:0]        hi;
    logic [EXP_W-1:0]        lo;
    logic [EXP_W-1:0]        diff;
    logic [EXP_W+12-1:0]     dprod;
    logic [EXP_W-1:0]        mant;
    logic [EXP_W-1:0]        value_reg;

    // Stage one: base-two exponent y = -x * log2(e), Q16.
    always_comb
    begin
        mag   = (arg < 0) ? ARG_W'(-arg) : '0;
        yprod = (ARG_W + 17)'(mag) * (ARG_W + 17)'(LOG2E_Q16);
    end

    always_ff @(posedge clk)
    begin
        y_reg <= yprod[ARG_W+17-1:12];
    end

    // Stage two: interpolated mantissa, then the integer shift.
    always_comb
    begin
        k     = y_reg[Y_W-1:16];
        idx   = y_reg[15:12];
        fr    = y_reg[11:0];
        hi    = pow2_tab({1'b0, idx});
        lo    = pow2_tab({1'b0, idx} + 5'd1);
        diff  = hi - lo;
        dprod = (EXP_W + 12)'(diff) * (EXP_W + 12)'(fr);
        mant  = hi - dprod[EXP_W+12-1:12];
    end

    always_ff @(posedge clk)
    begin
        if (k >= 7'd17)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= mant >> k;
        end
    end

    assign value = value_reg;

endmodule

### hw/rtl/sogh_div.sv
module sogh_div (
    input  logic               clk,
    input  logic               rst_n,
    input  sogh_pkg::div_req_t req,
    output sogh_pkg::div_rsp_t rsp
);
    import sogh_pkg::*;

    logic [ESUM_W-1:0] rem_reg;
    logic [ESUM_W-1:0] dvs_reg;
    logic [EXP_W-1:0]  bits_reg;
    logic [EXP_W-1:0]  q_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ESUM_W:0]   trial;
    logic              ge;

    // One quotient bit per cycle; the caller guarantees a quotient below 2^17.
    always_comb
    begin
        trial = {rem_reg, bits_reg[EXP_W-1]};
        ge    = trial >= (ESUM_W + 1)'(dvs_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= ESUM_W'(req.em[EXP_W-1:1]);
                bits_reg <= {req.em[0], {(EXP_W-1){1'b0}}};
                dvs_reg  <= req.esum;
                q_reg    <= '0;
                cnt_reg  <= 5'(EXP_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? ESUM_W'(trial - (ESUM_W + 1)'(dvs_reg)) : trial[ESUM_W-1:0];
                bits_reg <= {bits_reg[EXP_W-2:0], 1'b0};
                q_reg    <= {q_reg[EXP_W-2:0], ge};
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

### hw/rtl/sogh_merge.sv
module sogh_merge (
    input  logic                                            clk,
    input  logic [sogh_pkg::NUM_SCORES-1:0][sogh_pkg::VAL_W-1:0] vals,
    input  logic [sogh_pkg::NUM_SCORES-1:0]                  en,
    output logic [sogh_pkg::SUM_W-1:0]                      sum
);
    import sogh_pkg::*;

    logic [SUM_W-1:0] sum_c;
    logic [SUM_W-1:0] sum_reg;

    // Adds the enabled lane values.
    always_comb
    begin
        sum_c = '0;
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            if (en[i])
            begin
                sum_c = sum_c + SUM_W'(vals[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_c;
    end

    assign sum = sum_reg;

endmodule

### hw/rtl/softmax_ordinal_grad_hess_accum.sv
// Per-mode softmax cross-entropy gradient and hessian accumulator with an
// ordinal penalty. Each input transaction carries a command, a label, a mode
// and eight Q4.12 class scores; every transaction returns one result with the
// gradient and hessian sums of mode_id and the sample count, taken after the
// command. Clear and read commands skip the arithmetic. An add or subtract
// first builds the capped score ratios in eight parallel exp lanes, then
// scans all eight modes, passing over a mode that is not selected; for a
// selected one the iterative divider forms the softmax probability unless
// the sum is zero or the quotient is at least two. A new transaction is
// taken once the previous one has moved to the output register.
// Accumulators saturate at the signed accumulator limits and the count wraps.
// The user must write configuration over the APB port only while idle; the
// block itself does not enforce this.
module softmax_ordinal_grad_hess_accum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  sogh_pkg::item_t item,
    output logic            result_valid,
    input  logic            result_stall,
    output sogh_pkg::result_t result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import sogh_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_MSEL, ST_MX, ST_E0,
        ST_E1, ST_E2, ST_DPREP, ST_DIV, ST_PP, ST_GH, ST_HC, ST_ACC, ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic [3:0]  num_classes_reg;
    logic [7:0]  mode_mask_reg;
    logic [15:0] strength_reg;

    // Transaction and loop registers.
    item_t       item_reg;
    logic [2:0]  m_reg;
    logic signed [SCORE_W-1:0] mx_reg;
    logic [VAL_W-1:0] w_reg [NUM_SCORES];
    logic [SUM_W-1:0] t_reg [NUM_SCORES];
    logic [EXP_W-1:0] em_reg;
    logic [EXP_W-1:0] p_reg;
    logic [EXP_W-1:0] pp_reg;
    logic signed [DELTA_W-1:0] g_reg;
    logic [H0_W-1:0]  h0_reg;
    logic signed [DELTA_W-1:0] dg_reg;
    logic signed [DELTA_W-1:0] dh_reg;
    logic signed [ACC_WIDTH-1:0] gacc_reg [MAX_CLASSES];
    logic signed [ACC_WIDTH-1:0] hacc_reg [MAX_CLASSES];
    logic [CNT_W-1:0] count_reg;
    logic        result_valid_reg;
    result_t     result_reg;

    logic signed [SCORE_W-1:0] s_arr [NUM_SCORES];
    logic [3:0]  c_use;
    logic signed [SCORE_W-1:0] mx_c;
    logic [NUM_SCORES-1:0][VAL_W-1:0] mval;
    logic [NUM_SCORES-1:0] men;
    logic [SUM_W-1:0] merge_sum;
    logic signed [ARG_W-1:0] lane_arg [NUM_SCORES];
    logic [EXP_W-1:0] lane_val [NUM_SCORES];
    logic [VAL_W-1:0] w_c [NUM_SCORES];
    logic [SUM_W-1:0] t_c [NUM_SCORES];
    logic [SUM_W+16-1:0] tl_prod;
    logic        accept;
    logic        is_sub;
    logic        is_all;
    logic        m_sel;
    logic        m_last;
    logic        is_label;
    logic [ESUM_W-1:0] esum;
    logic        fast;
    logic [EXP_W-1:0] p_div;
    logic [2*EXP_W-1:0] pp_prod;
    logic [DELTA_W-1:0] h_c;
    logic [MODE_W-1:0] rd_idx;
    logic        mode_ok;
    logic signed [63:0] gext;
    logic signed [63:0] hext;
    logic        out_load;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Saturating accumulate at the signed accumulator limits.
    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [DELTA_W-1:0]   delta
    );
        logic signed [ACC_WIDTH:0] s;
        logic signed [ACC_WIDTH-1:0] r;
        s = (ACC_WIDTH + 1)'(acc) + (ACC_WIDTH + 1)'(delta);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
        begin
            r = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        else
        begin
            r = s[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= 4'd8;
            mode_mask_reg   <= 8'hFF;
            strength_reg    <= 16'd66;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_NUM_CLASSES: num_classes_reg <= pwdata[3:0];
                REG_MODE_MASK:   mode_mask_reg   <= pwdata[7:0];
                REG_STRENGTH:    strength_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NUM_CLASSES: prdata = {28'd0, num_classes_reg};
            REG_MODE_MASK:   prdata = {24'd0, mode_mask_reg};
            REG_STRENGTH:    prdata = {16'd0, strength_reg};
            default:         prdata = '0;
        endcase
    end

    // Scores and the clamped class count.
    assign s_arr[0] = item_reg.score_0;
    assign s_arr[1] = item_reg.score_1;
    assign s_arr[2] = item_reg.score_2;
    assign s_arr[3] = item_reg.score_3;
    assign s_arr[4] = item_reg.score_4;
    assign s_arr[5] = item_reg.score_5;
    assign s_arr[6] = item_reg.score_6;
    assign s_arr[7] = item_reg.score_7;

    always_comb
    begin
        if (num_classes_reg < 4'd2)
        begin
            c_use = 4'd2;
        end
        else if (num_classes_reg > 4'(MAX_CLASSES))
        begin
            c_use = 4'(MAX_CLASSES);
        end
        else
        begin
            c_use = num_classes_reg;
        end
    end

    assign accept   = item_valid && !item_stall;
    assign is_sub   = item_reg.cmd inside {CMD_SUB_ALL, CMD_SUB_ONE};
    assign is_all   = item_reg.cmd inside {CMD_ADD_ALL, CMD_SUB_ALL};
    assign is_label = m_reg == item_reg.label;
    assign m_last   = m_reg == 3'(NUM_SCORES - 1);
    assign m_sel    = (32'(m_reg) < MAX_CLASSES)
                   && (is_all ? mode_mask_reg[m_reg] : (m_reg == item_reg.mode_id));

    // Softmax reference point for the current mode.
    always_comb
    begin
        mx_c = s_arr[m_reg];
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            if ((4'(i) < c_use) && (s_arr[i] > mx_c))
            begin
                mx_c = s_arr[i];
            end
        end
    end

    // Exp lanes: capped-ratio arguments first, then softmax arguments.
    always_comb
    begin
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            if (state_reg == ST_R0)
            begin
                lane_arg[i] = ARG_W'(s_arr[i]) - ARG_W'(s_arr[item_reg.label])
                            - ARG_W'(LN2_Q12);
            end
            else
            begin
                lane_arg[i] = ARG_W'(s_arr[i]) - ARG_W'(mx_reg);
            end
        end
    end

    for (genvar g = 0; g < NUM_SCORES; g++)
    begin : g_lane
        sogh_lane u_lane (
            .clk   (clk),
            .arg   (lane_arg[g]),
            .value (lane_val[g])
        );
    end

    // Ratio weights and per-class penalty terms.
    always_comb
    begin
        logic signed [SCORE_W:0] d;
        logic [17:0]             ratio;
        logic [2:0]              ad;
        logic [5:0]              dd;
        logic [23:0]             wp;
        logic [VAL_W+16-1:0]     tp;
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            d     = (SCORE_W + 1)'(s_arr[i]) - (SCORE_W + 1)'(s_arr[item_reg.label]);
            ratio = (d >= (SCORE_W + 1)'(LN2_Q12)) ? 18'(2 * Q16_ONE) : {lane_val[i], 1'b0};
            ad    = (3'(i) > item_reg.label) ? 3'(i) - item_reg.label : item_reg.label - 3'(i);
            dd    = 6'(ad) * 6'(ad);
            wp    = 24'(dd) * 24'(ratio);
            w_c[i] = wp[VAL_W-1:0];
            tp    = (VAL_W + 16)'(w_reg[i]) * (VAL_W + 16)'(strength_reg);
            t_c[i] = SUM_W'(tp[VAL_W+16-1:16]);
        end
    end

    assign tl_prod = (SUM_W + 16)'(merge_sum) * (SUM_W + 16)'(strength_reg);

    // Merging stage: penalty sum in R3, softmax denominator in E2.
    always_comb
    begin
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            if (state_reg == ST_R3)
            begin
                mval[i] = w_reg[i];
                men[i]  = (4'(i) < c_use) && (3'(i) != item_reg.label);
            end
            else
            begin
                mval[i] = VAL_W'(lane_val[i]);
                men[i]  = 4'(i) < c_use;
            end
        end
    end

    sogh_merge u_merge (
        .clk  (clk),
        .vals (mval),
        .en   (men),
        .sum  (merge_sum)
    );

    // Probability: fast path when the sum is zero or the quotient is at least two.
    assign esum = merge_sum[ESUM_W-1:0];
    assign fast = (esum == '0) || ((ESUM_W + 1)'(em_reg) >= {esum, 1'b0});
    assign div_req.start = (state_reg == ST_DPREP) && !fast;
    assign div_req.em    = em_reg;
    assign div_req.esum  = esum;

    sogh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign p_div   = (div_rsp.q > EXP_W'(Q16_ONE)) ? EXP_W'(Q16_ONE) : div_rsp.q;
    assign pp_prod = (2 * EXP_W)'(EXP_W'(Q16_ONE) - p_reg) * (2 * EXP_W)'(p_reg);
    assign h_c     = DELTA_W'(h0_reg) * DELTA_W'(c_use);

    // Accumulator read port, shared by the update and the result.
    assign rd_idx  = (state_reg == ST_FIN) ? item_reg.mode_id[MODE_W-1:0] : m_reg[MODE_W-1:0];
    assign mode_ok = 32'(item_reg.mode_id) < MAX_CLASSES;
    assign gext    = 64'(gacc_reg[rd_idx]);
    assign hext    = 64'(hacc_reg[rd_idx]);
    assign out_load = (state_reg == ST_FIN) && (!result_valid_reg || !result_stall);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.cmd inside {CMD_ADD_ALL, CMD_SUB_ALL, CMD_ADD_ONE,
                                                   CMD_SUB_ONE}) ? ST_R0 : ST_FIN;
                end
            end
            ST_R0:    state_next = ST_R1;
            ST_R1:    state_next = ST_R2;
            ST_R2:    state_next = ST_R3;
            ST_R3:    state_next = ST_R4;
            ST_R4:    state_next = ST_MSEL;
            ST_MSEL:
            begin
                if (m_sel)
                begin
                    state_next = ST_MX;
                end
                else if (m_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MX:    state_next = ST_E0;
            ST_E0:    state_next = ST_E1;
            ST_E1:    state_next = ST_E2;
            ST_E2:    state_next = ST_DPREP;
            ST_DPREP: state_next = fast ? ST_PP : ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PP;
                end
            end
            ST_PP:    state_next = ST_GH;
            ST_GH:    state_next = ST_HC;
            ST_HC:    state_next = ST_ACC;
            ST_ACC:   state_next = m_last ? ST_FIN : ST_MSEL;
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_reg            <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                gacc_reg[i] <= '0;
                hacc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Accept: the sample count and commands that need no arithmetic act at once.
            if (accept)
            begin
                item_reg <= item;
                m_reg    <= '0;
                case (item.cmd)
                    CMD_ADD_ALL, CMD_ADD_ONE: count_reg <= count_reg + 32'd1;
                    CMD_SUB_ALL, CMD_SUB_ONE: count_reg <= count_reg - 32'd1;
                    CMD_CLEAR_ALL:
                    begin
                        count_reg <= '0;
                        for (int i = 0; i < MAX_CLASSES; i++)
                        begin
                            gacc_reg[i] <= '0;
                            hacc_reg[i] <= '0;
                        end
                    end
                    CMD_CLEAR_ONE:
                    begin
                        count_reg <= '0;
                        if (32'(item.mode_id) < MAX_CLASSES)
                        begin
                            gacc_reg[item.mode_id[MODE_W-1:0]] <= '0;
                            hacc_reg[item.mode_id[MODE_W-1:0]] <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                ST_R2:
                begin
                    for (int i = 0; i < NUM_SCORES; i++)
                    begin
                        w_reg[i] <= w_c[i];
                    end
                end
                ST_R3:
                begin
                    for (int i = 0; i < NUM_SCORES; i++)
                    begin
                        t_reg[i] <= t_c[i];
                    end
                end
                ST_R4:    t_reg[item_reg.label] <= tl_prod[SUM_W+16-1:16];
                ST_MSEL:
                begin
                    if (!m_sel && !m_last)
                    begin
                        m_reg <= m_reg + 3'd1;
                    end
                end
                ST_MX:    mx_reg <= mx_c;
                ST_E2:    em_reg <= lane_val[m_reg];
                ST_DPREP:
                begin
                    if (fast)
                    begin
                        p_reg <= EXP_W'(Q16_ONE);
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        p_reg <= p_div;
                    end
                end
                ST_PP:    pp_reg <= pp_prod[EXP_W+16-1:16];
                ST_GH:
                begin
                    if (is_label)
                    begin
                        g_reg <= DELTA_W'(p_reg) - DELTA_W'(Q16_ONE) - DELTA_W'(t_reg[m_reg]);
                    end
                    else
                    begin
                        g_reg <= DELTA_W'(p_reg) + DELTA_W'(t_reg[m_reg]);
                    end
                    h0_reg <= H0_W'(pp_reg) + H0_W'(strength_reg) + H0_W'(t_reg[m_reg]);
                end
                ST_HC:
                begin
                    dg_reg <= is_sub ? -g_reg : g_reg;
                    dh_reg <= is_sub ? -$signed(h_c) : $signed(h_c);
                end
                ST_ACC:
                begin
                    gacc_reg[rd_idx] <= sat_add(gacc_reg[rd_idx], dg_reg);
                    hacc_reg[rd_idx] <= sat_add(hacc_reg[rd_idx], dh_reg);
                    if (!m_last)
                    begin
                        m_reg <= m_reg + 3'd1;
                    end
                end
                default: ;
            endcase

            // Output register.
            if (out_load)
            begin
                result_valid_reg        <= 1'b1;
                result_reg.gradient_sum <= mode_ok ? gext[OUT_W-1:0] : '0;
                result_reg.hessian_sum  <= mode_ok ? hext[OUT_W-1:0] : '0;
                result_reg.sample_count <= count_reg;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign item_stall   = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The divider only reports while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    // Only modes inside the store are updated.
    a_acc_mode_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> (32'(m_reg) < MAX_CLASSES))
        else $error("accumulator update outside the store");

    // The probability never exceeds one.
    a_prob_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PP) |-> (p_reg <= EXP_W'(Q16_ONE)))
        else $error("probability above one");

endmodule

### tb/sogh_checker.sv
module sogh_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  sogh_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  sogh_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sogh_pkg::*;

    localparam longint ACC_HI = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    // 2^(-j/16) in Q16, j = 0..16.
    localparam longint unsigned MANT [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    // Shadow copy of the block's state and configuration.
    longint grad_store [MAX_CLASSES];
    longint hess_store [MAX_CLASSES];
    logic [31:0] net_samples;
    logic [3:0]  class_reg;
    logic [7:0]  mask_reg;
    logic [15:0] weight_reg;

    result_t sums_due [$];

    assign pending = sums_due.size();

    // exp(x) for x <= 0, x in Q.12, result in Q16.
    function automatic longint unsigned exp_q16(input int x);
        longint unsigned mag;
        longint unsigned y;
        longint unsigned k;
        longint unsigned fr;
        longint unsigned m;
        int idx;
        mag = (x < 0) ? longint'(-longint'(x)) : 0;
        y = (mag * 94548) >> 12;
        k = y >> 16;
        idx = int'((y >> 12) & 15);
        fr = y & 12'hFFF;
        if (k >= 17)
            return 0;
        m = MANT[idx] - (((MANT[idx] - MANT[idx + 1]) * fr) >> 12);
        return m >> k;
    endfunction

    // Score ratio to the label, capped at 2, in Q16.
    function automatic longint unsigned ratio_q16(input int d);
        if (d >= LN2_Q12)
            return 2 * Q16_ONE;
        return exp_q16(d - LN2_Q12) << 1;
    endfunction

    // Gradient and hessian contribution of one sample to one mode.
    function automatic void mode_terms(input int s [8], input int label, input int mode,
                                       output longint g, output longint h);
        int c;
        int mx;
        longint unsigned esum;
        longint unsigned em;
        longint unsigned p;
        longint unsigned penalty;
        longint unsigned r;
        longint unsigned t;
        longint unsigned dd;
        c = int'(class_reg);
        if (c < 2)
            c = 2;
        if (c > MAX_CLASSES)
            c = MAX_CLASSES;
        r = weight_reg;
        mx = s[mode];
        esum = 0;
        penalty = 0;
        for (int i = 0; i < c; i++)
            if (s[i] > mx)
                mx = s[i];
        for (int i = 0; i < c; i++) begin
            esum += exp_q16(s[i] - mx);
            if (i != label) begin
                dd = longint'((i - label) * (i - label));
                penalty += dd * ratio_q16(s[i] - s[label]);
            end
        end
        em = exp_q16(s[mode] - mx);
        p = (esum != 0) ? (em << 16) / esum : Q16_ONE;
        if (p > Q16_ONE)
            p = Q16_ONE;
        g = longint'(p);
        h = longint'(((Q16_ONE - p) * p) >> 16) + longint'(r);
        if (mode == label) begin
            t = (r * penalty) >> 16;
            g -= Q16_ONE + longint'(t);
            h += longint'(t);
        end
        else begin
            dd = longint'((mode - label) * (mode - label));
            t = (ratio_q16(s[mode] - s[label]) * r * dd) >> 16;
            g += longint'(t);
            h += longint'(t);
        end
        h = h * c;
    endfunction

    function automatic longint sat_sum(input longint acc, input longint delta);
        if (delta > 0 && acc > ACC_HI - delta)
            return ACC_HI;
        if (delta < 0 && acc < ACC_LO - delta)
            return ACC_LO;
        return acc + delta;
    endfunction

    function automatic void fold_mode(input int s [8], input int label, input int mode,
                                      input bit negate);
        longint g;
        longint h;
        if (mode >= MAX_CLASSES)
            return;
        mode_terms(s, label, mode, g, h);
        if (negate) begin
            g = -g;
            h = -h;
        end
        grad_store[mode] = sat_sum(grad_store[mode], g);
        hess_store[mode] = sat_sum(hess_store[mode], h);
    endfunction

    // Applies one command to the shadow state and returns the sums it reports.
    function automatic result_t accumulate(input item_t it);
        int s [8];
        int label;
        int mode;
        result_t r;
        s[0] = int'(it.score_0);
        s[1] = int'(it.score_1);
        s[2] = int'(it.score_2);
        s[3] = int'(it.score_3);
        s[4] = int'(it.score_4);
        s[5] = int'(it.score_5);
        s[6] = int'(it.score_6);
        s[7] = int'(it.score_7);
        label = int'(it.label);
        mode = int'(it.mode_id);
        case (it.cmd)
            CMD_ADD_ALL, CMD_SUB_ALL:
            begin
                for (int i = 0; i < MAX_CLASSES; i++)
                    if (mask_reg[i])
                        fold_mode(s, label, i, it.cmd == CMD_SUB_ALL);
                net_samples += (it.cmd == CMD_ADD_ALL) ? 32'd1 : 32'hFFFF_FFFF;
            end
            CMD_ADD_ONE, CMD_SUB_ONE:
            begin
                fold_mode(s, label, mode, it.cmd == CMD_SUB_ONE);
                net_samples += (it.cmd == CMD_ADD_ONE) ? 32'd1 : 32'hFFFF_FFFF;
            end
            CMD_CLEAR_ALL:
            begin
                for (int i = 0; i < MAX_CLASSES; i++)
                begin
                    grad_store[i] = 0;
                    hess_store[i] = 0;
                end
                net_samples = 0;
            end
            CMD_CLEAR_ONE:
            begin
                if (mode < MAX_CLASSES)
                begin
                    grad_store[mode] = 0;
                    hess_store[mode] = 0;
                end
                net_samples = 0;
            end
            default:
            begin
            end
        endcase
        if (mode < MAX_CLASSES)
        begin
            r.gradient_sum = grad_store[mode][OUT_W-1:0];
            r.hessian_sum = hess_store[mode][OUT_W-1:0];
        end
        else
        begin
            r.gradient_sum = '0;
            r.hessian_sum = '0;
        end
        r.sample_count = net_samples;
        return r;
    endfunction

    // Snoop configuration writes, predict accepted items, compare results.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                grad_store[i] = 0;
                hess_store[i] = 0;
            end
            net_samples = 0;
            class_reg = 4'd8;
            mask_reg = 8'hFF;
            weight_reg = 16'd66;
            fail_count = 0;
            sums_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_NUM_CLASSES: class_reg = pwdata[3:0];
                    REG_MODE_MASK:   mask_reg = pwdata[7:0];
                    REG_STRENGTH:    weight_reg = pwdata[15:0];
                    default:         ;
                endcase
            end
            if (item_valid && !item_stall)
                sums_due.push_back(accumulate(item));
            if (result_valid && !result_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (result.gradient_sum !== want.gradient_sum)
                    begin
                        $error("gradient_sum expected %0d got %0d",
                               want.gradient_sum, result.gradient_sum);
                        fail_count++;
                    end
                    if (result.hessian_sum !== want.hessian_sum)
                    begin
                        $error("hessian_sum expected %0d got %0d",
                               want.hessian_sum, result.hessian_sum);
                        fail_count++;
                    end
                    if (result.sample_count !== want.sample_count)
                    begin
                        $error("sample_count expected %0d got %0d",
                               want.sample_count, result.sample_count);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sogh_pkg::*;

    localparam logic [2:0] CMD_READ   = 3'd6;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          no_idle;

    softmax_ordinal_grad_hess_accum dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sogh_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on the run.
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int gap_draw();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // Result side: stall a random number of cycles before each transaction.
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = gap_draw();
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for the block to drain, then writes all three registers.
    task automatic configure(input logic [3:0] c, input logic [7:0] m, input logic [15:0] r);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        reg_write(REG_NUM_CLASSES, {28'd0, c});
        reg_write(REG_MODE_MASK, {24'd0, m});
        reg_write(REG_STRENGTH, {16'd0, r});
    endtask

    task automatic send(input item_t it);
        int n;
        n = gap_draw();
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
    endtask

    function automatic item_t make_item(input logic [2:0] cmd, input logic [2:0] label,
                                        input logic [2:0] mode, input bit spread);
        item_t it;
        logic signed [15:0] base;
        logic signed [15:0] sc [8];
        base = 16'($urandom_range(0, 16383)) - 16'sd8192;
        for (int i = 0; i < 8; i++)
            if (spread)
                sc[i] = 16'($urandom());
            else
                sc[i] = base + $signed(16'($urandom_range(0, 12000)) - 16'sd6000);
        it.cmd = cmd;
        it.label = label;
        it.mode_id = mode;
        {it.score_0, it.score_1, it.score_2, it.score_3,
         it.score_4, it.score_5, it.score_6, it.score_7} =
            {sc[0], sc[1], sc[2], sc[3], sc[4], sc[5], sc[6], sc[7]};
        return it;
    endfunction

    function automatic item_t flat_item(input logic [2:0] cmd, input logic [2:0] label,
                                        input logic [2:0] mode, input logic signed [15:0] v);
        item_t it;
        it.cmd = cmd;
        it.label = label;
        it.mode_id = mode;
        {it.score_0, it.score_1, it.score_2, it.score_3,
         it.score_4, it.score_5, it.score_6, it.score_7} = {8{v}};
        return it;
    endfunction

    function automatic logic [2:0] random_cmd();
        int w;
        w = $urandom_range(0, 99);
        if (w < 30) return CMD_ADD_ALL;
        if (w < 45) return CMD_SUB_ALL;
        if (w < 65) return CMD_ADD_ONE;
        if (w < 78) return CMD_SUB_ONE;
        if (w < 82) return CMD_CLEAR_ALL;
        if (w < 86) return CMD_CLEAR_ONE;
        if (w < 96) return CMD_READ;
        return CMD_UNUSED;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        item_t it;
        logic [3:0] c;
        logic [7:0] m;
        logic [15:0] r;
        item_valid = 1'b0;
        item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        // Directed part under the reset configuration.
        send(flat_item(CMD_READ, 3'd0, 3'd0, 16'sd0));
        send(flat_item(CMD_SUB_ONE, 3'd0, 3'd0, 16'sd0));
        send(flat_item(CMD_ADD_ALL, 3'd3, 3'd3, 16'sd32767));
        send(flat_item(CMD_ADD_ALL, 3'd7, 3'd0, -16'sd32768));
        it = flat_item(CMD_ADD_ONE, 3'd0, 3'd7, -16'sd32768);
        it.score_7 = 16'sd32767;
        send(it);
        it = flat_item(CMD_ADD_ONE, 3'd7, 3'd0, -16'sd32768);
        it.score_0 = 16'sd32767;
        send(it);
        it = flat_item(CMD_SUB_ALL, 3'd2, 3'd2, 16'sd0);
        it.score_5 = 16'sd2839;
        it.score_6 = 16'sd2838;
        send(it);
        send(make_item(CMD_ADD_ONE, 3'd4, 3'd4, 1'b0));
        send(flat_item(CMD_UNUSED, 3'd0, 3'd4, 16'sd0));
        send(flat_item(CMD_CLEAR_ONE, 3'd0, 3'd4, 16'sd0));
        send(flat_item(CMD_READ, 3'd0, 3'd3, 16'sd0));
        send(flat_item(CMD_CLEAR_ALL, 3'd0, 3'd3, 16'sd0));
        send(flat_item(CMD_SUB_ONE, 3'd1, 3'd6, 16'sd100));

        // Few classes: modes outside the classes and an empty softmax sum.
        configure(4'd2, 8'hC1, 16'd0);
        it = flat_item(CMD_ADD_ALL, 3'd1, 3'd7, -16'sd32768);
        it.score_7 = 16'sd32767;
        send(it);
        send(make_item(CMD_ADD_ONE, 3'd5, 3'd6, 1'b1));
        send(make_item(CMD_READ, 3'd0, 3'd7, 1'b0));
        configure(4'd8, 8'hFF, 16'hFFFF);
        send(flat_item(CMD_ADD_ALL, 3'd0, 3'd0, 16'sd0));
        send(make_item(CMD_SUB_ALL, 3'd7, 3'd1, 1'b1));
        send(make_item(CMD_READ, 3'd7, 3'd1, 1'b0));

        // Random phases with changing configuration.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin c = 4'd8; m = 8'hFF; r = 16'd66; end
                1: begin c = 4'd0; m = 8'h00; r = 16'hFFFF; end
                2: begin c = 4'd15; m = 8'hA5; r = 16'd0; end
                3: begin c = 4'd2; m = 8'h03; r = 16'd30000; end
                default:
                begin
                    c = 4'($urandom_range(0, 15));
                    m = 8'($urandom());
                    r = 16'($urandom());
                end
            endcase
            configure(c, m, r);
            for (int k = 0; k < 230; k++)
            begin
                if (k % 60 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                send(make_item(random_cmd(), 3'($urandom()), 3'($urandom()),
                               $urandom_range(0, 3) == 0));
            end
            no_idle = 1'b0;
        end
        item_valid <= 1'b0;

        // Drain and settle.
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sogh_pkg.sv
hw/rtl/sogh_lane.sv
hw/rtl/sogh_div.sv
hw/rtl/sogh_merge.sv
hw/rtl/softmax_ordinal_grad_hess_accum.sv
tb/sogh_checker.sv
tb/testbench.sv
